// ===== src/rsb_pkg.sv =====
package rsb_pkg;

    localparam int PENDING_DEPTH_DEF = 32;
    localparam int FLIGHT_SLOTS_DEF  = 8;
    localparam int FAILURE_DEPTH_DEF = 32;
    localparam int KEY_BITS_DEF      = 32;

    localparam int TIME_W    = 48;
    localparam int OUT_KEY_W = 32;
    localparam int COUNT_W   = 6;
    localparam int STAT_W    = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int MAXF_W    = 4;
    localparam int STALE_W   = 32;
    localparam int BACKOFF_W = 16;
    localparam int GRANT_W   = 4;
    localparam int MAX_GRANTS = 8;

    localparam logic [CMD_W-1:0] CMD_WANT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_QUEUED    = 4'd0;
    localparam logic [STAT_W-1:0] STAT_REFRESHED = 4'd1;
    localparam logic [STAT_W-1:0] STAT_IN_FLIGHT = 4'd2;
    localparam logic [STAT_W-1:0] STAT_BACKOFF   = 4'd3;
    localparam logic [STAT_W-1:0] STAT_PEND_FULL = 4'd4;
    localparam logic [STAT_W-1:0] STAT_GRANTED   = 4'd5;
    localparam logic [STAT_W-1:0] STAT_NONE      = 4'd6;
    localparam logic [STAT_W-1:0] STAT_OK        = 4'd7;
    localparam logic [STAT_W-1:0] STAT_FAILED    = 4'd8;
    localparam logic [STAT_W-1:0] STAT_FAIL_FULL = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_IN_FLIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_AFTER   = 2'd1;

    localparam logic [MAXF_W-1:0]  MAX_IN_FLIGHT_RST = 4'd4;
    localparam logic [STALE_W-1:0] STALE_AFTER_RST   = 32'd2000;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 6'd63;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [OUT_KEY_W-1:0] key;
        logic                 fetch_ok;
        logic [TIME_W-1:0]    now_ms;
    } req_t;

    typedef struct packed {
        logic [OUT_KEY_W-1:0] out_key;
        logic [STAT_W-1:0]    status;
        logic [TIME_W-1:0]    retry_time;
        logic                 last;
    } rsp_t;

    typedef struct packed {
        logic alloc;
        logic free;
    } flight_ctl_t;

    function automatic logic [BACKOFF_W-1:0] backoff_ms(input logic [COUNT_W-1:0] count);
        logic [BACKOFF_W-1:0] ms;
        if (count <= 6'd1)
            ms = 16'd2000;
        else if (count == 6'd2)
            ms = 16'd4000;
        else if (count == 6'd3)
            ms = 16'd8000;
        else if (count == 6'd4)
            ms = 16'd16000;
        else if (count == 6'd5)
            ms = 16'd32000;
        else
            ms = 16'd60000;
        return ms;
    endfunction

endpackage

// ===== src/rsb_ram.sv =====
module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rsb_flight.sv =====
module rsb_flight #(
    parameter int SLOTS    = rsb_pkg::FLIGHT_SLOTS_DEF,
    parameter int KEY_BITS = rsb_pkg::KEY_BITS_DEF,
    localparam int UW = $clog2(SLOTS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_BITS-1:0] lookup_key,
    output logic                hit,
    input  rsb_pkg::flight_ctl_t ctl,
    input  logic [KEY_BITS-1:0] alloc_key,
    output logic [UW-1:0]       used
);

    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [KEY_BITS-1:0] keys_reg [SLOTS];
    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    valid_next;
    logic [SAW-1:0]      hit_idx;
    logic [SAW-1:0]      free_idx;

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && keys_reg[i] == lookup_key)
            begin
                hit     = 1'b1;
                hit_idx = SAW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = SAW'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.free && hit)
        begin
            valid_next[hit_idx] = 1'b0;
        end
        if (ctl.alloc)
        begin
            valid_next[free_idx] = 1'b1;
        end
    end

    assign used = UW'($countones(valid_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.alloc)
        begin
            keys_reg[free_idx] <= alloc_key;
        end
    end

endmodule

// ===== src/request_scheduler_with_backoff_top.sv =====
// Request scheduler with exponential backoff. One command is worked at a time; req_stall is
// high from acceptance until the command's last result has been loaded into the output
// register. Pending keys and stamps live in one RAM, failure records in another, in-flight
// slots in flops. A finish, or a want whose key is not in flight, scans the whole failure
// RAM and then decides; a want that goes on to the pending list scans it too, if it is not
// empty, then posts its result. A take that is under the in-flight limit sweeps the pending
// RAM and then reads, waits and emits for each grant, as the pending RAM has one read port. No
// clearing pass after reset: valid bits and a fill count cover the RAMs.
module request_scheduler_with_backoff_top #(
    parameter int PENDING_DEPTH = rsb_pkg::PENDING_DEPTH_DEF,
    parameter int FLIGHT_SLOTS  = rsb_pkg::FLIGHT_SLOTS_DEF,
    parameter int FAILURE_DEPTH = rsb_pkg::FAILURE_DEPTH_DEF,
    parameter int KEY_BITS      = rsb_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  rsb_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output rsb_pkg::rsp_t                       rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsb_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int TW  = rsb_pkg::TIME_W;
    localparam int CW  = rsb_pkg::COUNT_W;
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int FAW = (FAILURE_DEPTH > 1) ? $clog2(FAILURE_DEPTH) : 1;
    localparam int FCW = $clog2(FAILURE_DEPTH + 1);
    localparam int UW  = $clog2(FLIGHT_SLOTS + 1);
    localparam int LW  = (UW > rsb_pkg::MAXF_W) ? UW : rsb_pkg::MAXF_W;
    localparam int PW  = KEY_BITS + TW;
    localparam int FW  = KEY_BITS + CW + TW;
    localparam int GW  = rsb_pkg::GRANT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FSCAN = 4'd1;
    localparam logic [3:0] S_FDEC  = 4'd2;
    localparam logic [3:0] S_PSCAN = 4'd3;
    localparam logic [3:0] S_PINS  = 4'd4;
    localparam logic [3:0] S_SWEEP = 4'd5;
    localparam logic [3:0] S_GRD   = 4'd6;
    localparam logic [3:0] S_GWAIT = 4'd7;
    localparam logic [3:0] S_GEMIT = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [rsb_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic ok_reg, ok_next;
    logic [TW-1:0] now_reg, now_next;
    logic [PCW-1:0] pcnt_reg, pcnt_next;
    logic [PCW-1:0] paddr_reg, paddr_next;
    logic [FCW-1:0] faddr_reg, faddr_next;
    logic dval_reg, dval_next;
    logic [PAW-1:0] pdidx_reg, pdidx_next;
    logic [FAW-1:0] fdidx_reg, fdidx_next;
    logic hit_reg, hit_next;
    logic [FAW-1:0] hidx_reg, hidx_next;
    logic [CW-1:0] hcnt_reg, hcnt_next;
    logic [TW-1:0] hretry_reg, hretry_next;
    logic free_found_reg, free_found_next;
    logic [FAW-1:0] free_idx_reg, free_idx_next;
    logic [PCW-1:0] kept_reg, kept_next;
    logic [GW-1:0] ngr_reg, ngr_next;
    logic [KEY_BITS-1:0] gkey_reg, gkey_next;
    logic [FAILURE_DEPTH-1:0] fvalid_reg, fvalid_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;
    logic [rsb_pkg::STAT_W-1:0] rstat_reg, rstat_next;
    logic [TW-1:0] rretry_reg, rretry_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsb_pkg::rsp_t rsp_reg, rsp_next;
    logic [rsb_pkg::MAXF_W-1:0] max_reg;
    logic [rsb_pkg::STALE_W-1:0] stale_reg;

    logic p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [PW-1:0] p_wdata, p_rdata;
    logic f_we;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [FW-1:0] f_wdata, f_rdata;

    logic [63:0] in_k64;
    logic [KEY_BITS-1:0] key_in;
    logic [63:0] rkey64, gkey64;
    logic fl_hit;
    rsb_pkg::flight_ctl_t fl_ctl;
    logic [UW-1:0] used;
    logic [LW-1:0] used_ext, max_ext, slots_c, limit;
    logic out_free;

    logic [KEY_BITS-1:0] p_rkey, f_rkey;
    logic [TW-1:0] p_rstamp, f_rretry;
    logic [CW-1:0] f_rcnt;
    logic keep;
    logic more;
    logic [CW-1:0] ncnt;
    logic [TW:0] rsum;
    logic [TW-1:0] rnew;
    logic [FAW-1:0] widx;

    assign in_k64 = 64'(req.key);
    assign key_in = in_k64[KEY_BITS-1:0];
    assign rkey64 = 64'(rkey_reg);
    assign gkey64 = 64'(gkey_reg);

    assign {p_rkey, p_rstamp} = p_rdata;
    assign {f_rkey, f_rcnt, f_rretry} = f_rdata;

    assign used_ext = LW'(used);
    assign max_ext  = LW'(max_reg);
    assign slots_c  = LW'(FLIGHT_SLOTS);
    assign limit    = (max_ext < slots_c) ? max_ext : slots_c;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign keep = (now_reg < p_rstamp) || ((now_reg - p_rstamp) <= TW'(stale_reg));
    assign more = ((used_ext + LW'(1)) < limit) && (pcnt_reg > PCW'(1))
                  && ((ngr_reg + GW'(1)) < GW'(rsb_pkg::MAX_GRANTS));
    assign ncnt = !hit_reg ? CW'(1) :
                  (hcnt_reg == rsb_pkg::COUNT_MAX) ? hcnt_reg : hcnt_reg + CW'(1);
    assign rsum = {1'b0, now_reg} + (TW + 1)'(rsb_pkg::backoff_ms(ncnt));
    assign rnew = rsum[TW] ? {TW{1'b1}} : rsum[TW-1:0];
    assign widx = hit_reg ? hidx_reg : free_idx_reg;

    rsb_ram #(.WIDTH(PW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rsb_ram #(.WIDTH(FW), .DEPTH(FAILURE_DEPTH)) u_fail_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    rsb_flight #(.SLOTS(FLIGHT_SLOTS), .KEY_BITS(KEY_BITS)) u_flight (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (key_in),
        .hit        (fl_hit),
        .ctl        (fl_ctl),
        .alloc_key  (gkey_reg),
        .used       (used)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        ok_next         = ok_reg;
        now_next        = now_reg;
        pcnt_next       = pcnt_reg;
        paddr_next      = paddr_reg;
        faddr_next      = faddr_reg;
        dval_next       = dval_reg;
        pdidx_next      = pdidx_reg;
        fdidx_next      = fdidx_reg;
        hit_next        = hit_reg;
        hidx_next       = hidx_reg;
        hcnt_next       = hcnt_reg;
        hretry_next     = hretry_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        kept_next       = kept_reg;
        ngr_next        = ngr_reg;
        gkey_next       = gkey_reg;
        fvalid_next     = fvalid_reg;
        rkey_next       = rkey_reg;
        rstat_next      = rstat_reg;
        rretry_next     = rretry_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        p_we    = 1'b0;
        p_waddr = pdidx_reg;
        p_wdata = {key_reg, now_reg};
        p_raddr = paddr_reg[PAW-1:0];
        f_we    = 1'b0;
        f_waddr = widx;
        f_wdata = {key_reg, ncnt, rnew};
        f_raddr = faddr_reg[FAW-1:0];
        fl_ctl  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req.command;
                    key_next        = key_in;
                    ok_next         = req.fetch_ok;
                    now_next        = req.now_ms;
                    rkey_next       = key_in;
                    rretry_next     = '0;
                    faddr_next      = '0;
                    paddr_next      = '0;
                    dval_next       = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    kept_next       = '0;
                    case (req.command)
                        rsb_pkg::CMD_WANT:
                        begin
                            if (fl_hit)
                            begin
                                rstat_next = rsb_pkg::STAT_IN_FLIGHT;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_FSCAN;
                            end
                        end
                        rsb_pkg::CMD_TAKE:
                        begin
                            if (used_ext >= limit)
                            begin
                                rkey_next  = '0;
                                rstat_next = rsb_pkg::STAT_NONE;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        rsb_pkg::CMD_FINISH:
                        begin
                            fl_ctl.free = 1'b1;
                            state_next  = S_FSCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FSCAN:
            begin
                if (faddr_reg < FCW'(FAILURE_DEPTH))
                begin
                    faddr_next = faddr_reg + FCW'(1);
                    dval_next  = 1'b1;
                    fdidx_next = faddr_reg[FAW-1:0];
                end
                else
                begin
                    dval_next = 1'b0;
                end
                if (dval_reg)
                begin
                    if (fvalid_reg[fdidx_reg] && f_rkey == key_reg && !hit_reg)
                    begin
                        hit_next    = 1'b1;
                        hidx_next   = fdidx_reg;
                        hcnt_next   = f_rcnt;
                        hretry_next = f_rretry;
                    end
                    if (!fvalid_reg[fdidx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = fdidx_reg;
                    end
                    if (fdidx_reg == FAW'(FAILURE_DEPTH - 1))
                    begin
                        state_next = S_FDEC;
                    end
                end
            end

            S_FDEC:
            begin
                dval_next = 1'b0;
                if (cmd_reg == rsb_pkg::CMD_WANT)
                begin
                    if (hit_reg && now_reg < hretry_reg)
                    begin
                        rstat_next  = rsb_pkg::STAT_BACKOFF;
                        rretry_next = hretry_reg;
                        state_next  = S_EMIT;
                    end
                    else if (pcnt_reg == '0)
                    begin
                        state_next = S_PINS;
                    end
                    else
                    begin
                        paddr_next = '0;
                        state_next = S_PSCAN;
                    end
                end
                else if (ok_reg)
                begin
                    if (hit_reg)
                    begin
                        fvalid_next[hidx_reg] = 1'b0;
                    end
                    rstat_next = rsb_pkg::STAT_OK;
                    state_next = S_EMIT;
                end
                else if (!hit_reg && !free_found_reg)
                begin
                    rstat_next = rsb_pkg::STAT_FAIL_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    f_we              = 1'b1;
                    fvalid_next[widx] = 1'b1;
                    rstat_next        = rsb_pkg::STAT_FAILED;
                    rretry_next       = rnew;
                    state_next        = S_EMIT;
                end
            end

            S_PSCAN:
            begin
                if (paddr_reg < pcnt_reg)
                begin
                    paddr_next = paddr_reg + PCW'(1);
                    dval_next  = 1'b1;
                    pdidx_next = paddr_reg[PAW-1:0];
                end
                else
                begin
                    dval_next = 1'b0;
                end
                if (dval_reg)
                begin
                    if (p_rkey == key_reg)
                    begin
                        p_we       = 1'b1;
                        rstat_next = rsb_pkg::STAT_REFRESHED;
                        state_next = S_EMIT;
                    end
                    else if (PCW'(pdidx_reg) + PCW'(1) == pcnt_reg)
                    begin
                        state_next = S_PINS;
                    end
                end
            end

            S_PINS:
            begin
                dval_next = 1'b0;
                if (pcnt_reg == PCW'(PENDING_DEPTH))
                begin
                    rstat_next = rsb_pkg::STAT_PEND_FULL;
                end
                else
                begin
                    p_we       = 1'b1;
                    p_waddr    = pcnt_reg[PAW-1:0];
                    pcnt_next  = pcnt_reg + PCW'(1);
                    rstat_next = rsb_pkg::STAT_QUEUED;
                end
                state_next = S_EMIT;
            end

            S_SWEEP:
            begin
                if (pcnt_reg == '0)
                begin
                    ngr_next   = '0;
                    state_next = S_GRD;
                end
                else
                begin
                    if (paddr_reg < pcnt_reg)
                    begin
                        paddr_next = paddr_reg + PCW'(1);
                        dval_next  = 1'b1;
                        pdidx_next = paddr_reg[PAW-1:0];
                    end
                    else
                    begin
                        dval_next = 1'b0;
                    end
                    if (dval_reg)
                    begin
                        if (keep)
                        begin
                            p_we      = 1'b1;
                            p_waddr   = kept_reg[PAW-1:0];
                            p_wdata   = p_rdata;
                            kept_next = kept_reg + PCW'(1);
                        end
                        if (PCW'(pdidx_reg) + PCW'(1) == pcnt_reg)
                        begin
                            pcnt_next  = keep ? kept_reg + PCW'(1) : kept_reg;
                            dval_next  = 1'b0;
                            ngr_next   = '0;
                            state_next = S_GRD;
                        end
                    end
                end
            end

            S_GRD:
            begin
                if (pcnt_reg == '0)
                begin
                    rkey_next  = '0;
                    rstat_next = rsb_pkg::STAT_NONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    p_raddr    = pcnt_reg[PAW-1:0] - PAW'(1);
                    state_next = S_GWAIT;
                end
            end

            S_GWAIT:
            begin
                gkey_next  = p_rkey;
                state_next = S_GEMIT;
            end

            S_GEMIT:
            begin
                if (out_free)
                begin
                    fl_ctl.alloc        = 1'b1;
                    pcnt_next           = pcnt_reg - PCW'(1);
                    ngr_next            = ngr_reg + GW'(1);
                    rsp_valid_next      = 1'b1;
                    rsp_next.out_key    = gkey64[rsb_pkg::OUT_KEY_W-1:0];
                    rsp_next.status     = rsb_pkg::STAT_GRANTED;
                    rsp_next.retry_time = '0;
                    rsp_next.last       = !more;
                    state_next          = more ? S_GRD : S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.out_key    = rkey64[rsb_pkg::OUT_KEY_W-1:0];
                    rsp_next.status     = rstat_reg;
                    rsp_next.retry_time = rretry_reg;
                    rsp_next.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcnt_reg      <= '0;
            fvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            dval_reg      <= 1'b0;
            max_reg       <= rsb_pkg::MAX_IN_FLIGHT_RST;
            stale_reg     <= rsb_pkg::STALE_AFTER_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pcnt_reg      <= pcnt_next;
            fvalid_reg    <= fvalid_next;
            rsp_valid_reg <= rsp_valid_next;
            dval_reg      <= dval_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rsb_pkg::REG_MAX_IN_FLIGHT: max_reg <= cfg_data[rsb_pkg::MAXF_W-1:0];
                    rsb_pkg::REG_STALE_AFTER:   stale_reg <= cfg_data;
                    default:                    max_reg <= max_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        ok_reg         <= ok_next;
        now_reg        <= now_next;
        paddr_reg      <= paddr_next;
        faddr_reg      <= faddr_next;
        pdidx_reg      <= pdidx_next;
        fdidx_reg      <= fdidx_next;
        hit_reg        <= hit_next;
        hidx_reg       <= hidx_next;
        hcnt_reg       <= hcnt_next;
        hretry_reg     <= hretry_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        kept_reg       <= kept_next;
        ngr_reg        <= ngr_next;
        gkey_reg       <= gkey_next;
        rkey_reg       <= rkey_next;
        rstat_reg      <= rstat_next;
        rretry_reg     <= rretry_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ===== src/rsb_checker.sv =====
module rsb_port_checks (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input rsb_pkg::rsp_t rsp
);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != rsb_pkg::STAT_BACKOFF
        && rsp.status != rsb_pkg::STAT_FAILED |-> rsp.retry_time == '0)
        else $error("retry time on a status without one");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != rsb_pkg::STAT_GRANTED |-> rsp.last)
        else $error("single result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == rsb_pkg::STAT_NONE |-> rsp.out_key == '0)
        else $error("none result carries a key");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == rsb_pkg::STAT_FAILED |-> rsp.retry_time != '0)
        else $error("failed result without retry time");

endmodule

bind request_scheduler_with_backoff_top rsb_port_checks u_rsb_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== sim/rsb_checker.sv =====
`timescale 1ns / 1ps

module rsb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  rsb_pkg::req_t                 req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  rsb_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rsb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsb_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            errors,
    output int                            outstanding
);

    localparam int PDEPTH = rsb_pkg::PENDING_DEPTH_DEF;
    localparam int SLOTS  = rsb_pkg::FLIGHT_SLOTS_DEF;
    localparam int FDEPTH = rsb_pkg::FAILURE_DEPTH_DEF;
    localparam int TW     = rsb_pkg::TIME_W;
    localparam int KW     = rsb_pkg::OUT_KEY_W;
    localparam int CW     = rsb_pkg::COUNT_W;
    localparam logic [TW-1:0] TIME_TOP = '1;

    logic [KW-1:0]                 pend_key [PDEPTH];
    logic [TW-1:0]                 pend_stamp [PDEPTH];
    int                            pend_cnt;
    logic [KW-1:0]                 slot_key [SLOTS];
    logic                          slot_busy [SLOTS];
    logic [KW-1:0]                 fail_key [FDEPTH];
    logic [CW-1:0]                 fail_cnt [FDEPTH];
    logic [TW-1:0]                 fail_retry [FDEPTH];
    logic                          fail_used [FDEPTH];
    logic [rsb_pkg::MAXF_W-1:0]    max_flight;
    logic [rsb_pkg::STALE_W-1:0]   stale_ms;

    rsb_pkg::rsp_t expected_rsp [$];

    assign outstanding = expected_rsp.size();

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic emit(input logic [KW-1:0] k, input logic [rsb_pkg::STAT_W-1:0] st,
                        input logic [TW-1:0] rt, input logic lst);
        rsb_pkg::rsp_t r;
        r.out_key    = k;
        r.status     = st;
        r.retry_time = rt;
        r.last       = lst;
        expected_rsp = {expected_rsp, r};
    endtask

    function automatic int find_slot(input logic [KW-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int find_fail(input logic [KW-1:0] k);
        for (int i = 0; i < FDEPTH; i++)
            if (fail_used[i] && fail_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic logic [TW:0] retry_wait(input logic [CW-1:0] c);
        int e;
        int secs;
        e = (c == '0) ? 0 : int'(c) - 1;
        if (e > 5)
            e = 5;
        secs = 2 << e;
        if (secs > 60)
            secs = 60;
        return (TW + 1)'(secs * 1000);
    endfunction

    task automatic predict_want(input logic [KW-1:0] k, input logic [TW-1:0] now);
        int f;
        if (find_slot(k) >= 0)
        begin
            emit(k, rsb_pkg::STAT_IN_FLIGHT, '0, 1'b1);
            return;
        end
        f = find_fail(k);
        if (f >= 0 && now < fail_retry[f])
        begin
            emit(k, rsb_pkg::STAT_BACKOFF, fail_retry[f], 1'b1);
            return;
        end
        for (int i = 0; i < pend_cnt; i++)
            if (pend_key[i] == k)
            begin
                pend_stamp[i] = now;
                emit(k, rsb_pkg::STAT_REFRESHED, '0, 1'b1);
                return;
            end
        if (pend_cnt >= PDEPTH)
        begin
            emit(k, rsb_pkg::STAT_PEND_FULL, '0, 1'b1);
            return;
        end
        pend_key[pend_cnt]   = k;
        pend_stamp[pend_cnt] = now;
        pend_cnt++;
        emit(k, rsb_pkg::STAT_QUEUED, '0, 1'b1);
    endtask

    task automatic predict_take(input logic [TW-1:0] now);
        int lim;
        int used;
        int kept;
        int n;
        int s;
        logic [TW-1:0] age;
        lim  = (int'(max_flight) > SLOTS) ? SLOTS : int'(max_flight);
        used = 0;
        kept = 0;
        n    = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i])
                used++;
        if (used >= lim)
        begin
            emit('0, rsb_pkg::STAT_NONE, '0, 1'b1);
            return;
        end
        for (int i = 0; i < pend_cnt; i++)
        begin
            age = (now >= pend_stamp[i]) ? now - pend_stamp[i] : '0;
            if ({16'd0, age} <= {32'd0, stale_ms})
            begin
                pend_key[kept]   = pend_key[i];
                pend_stamp[kept] = pend_stamp[i];
                kept++;
            end
        end
        pend_cnt = kept;
        while (used < lim && pend_cnt > 0 && n < rsb_pkg::MAX_GRANTS)
        begin
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!slot_busy[i])
                    s = i;
            if (s < 0)
                break;
            pend_cnt--;
            slot_busy[s] = 1'b1;
            slot_key[s]  = pend_key[pend_cnt];
            used++;
            emit(pend_key[pend_cnt], rsb_pkg::STAT_GRANTED, '0, 1'b0);
            n++;
        end
        if (n == 0)
            emit('0, rsb_pkg::STAT_NONE, '0, 1'b1);
        else
            expected_rsp[expected_rsp.size() - 1].last = 1'b1;
    endtask

    task automatic predict_finish(input logic [KW-1:0] k, input logic ok,
                                  input logic [TW-1:0] now);
        int s;
        int f;
        logic [TW:0] sum;
        s = find_slot(k);
        if (s >= 0)
            slot_busy[s] = 1'b0;
        f = find_fail(k);
        if (ok)
        begin
            if (f >= 0)
                fail_used[f] = 1'b0;
            emit(k, rsb_pkg::STAT_OK, '0, 1'b1);
            return;
        end
        if (f < 0)
        begin
            for (int i = FDEPTH - 1; i >= 0; i--)
                if (!fail_used[i])
                    f = i;
            if (f < 0)
            begin
                emit(k, rsb_pkg::STAT_FAIL_FULL, '0, 1'b1);
                return;
            end
            fail_used[f] = 1'b1;
            fail_key[f]  = k;
            fail_cnt[f]  = '0;
        end
        if (fail_cnt[f] < rsb_pkg::COUNT_MAX)
            fail_cnt[f]++;
        sum = {1'b0, now} + retry_wait(fail_cnt[f]);
        fail_retry[f] = sum[TW] ? TIME_TOP : sum[TW-1:0];
        emit(k, rsb_pkg::STAT_FAILED, fail_retry[f], 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt   = 0;
            max_flight = rsb_pkg::MAX_IN_FLIGHT_RST;
            stale_ms   = rsb_pkg::STALE_AFTER_RST;
            for (int i = 0; i < SLOTS; i++)
                slot_busy[i] = 1'b0;
            for (int i = 0; i < FDEPTH; i++)
                fail_used[i] = 1'b0;
            expected_rsp.delete();
            errors = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report($sformatf("unexpected item key %h status %0d", rsp.out_key,
                                     rsp.status));
                else
                begin
                    rsb_pkg::rsp_t e;
                    e = expected_rsp.pop_front();
                    if (rsp.out_key !== e.out_key)
                        report($sformatf("out_key %h, want %h", rsp.out_key, e.out_key));
                    if (rsp.status !== e.status)
                        report($sformatf("status %0d, want %0d", rsp.status, e.status));
                    if (rsp.retry_time !== e.retry_time)
                        report($sformatf("retry_time %h, want %h", rsp.retry_time,
                                         e.retry_time));
                    if (rsp.last !== e.last)
                        report($sformatf("last %b, want %b", rsp.last, e.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rsb_pkg::REG_MAX_IN_FLIGHT)
                    max_flight = cfg_data[rsb_pkg::MAXF_W-1:0];
                else if (cfg_index == rsb_pkg::REG_STALE_AFTER)
                    stale_ms = cfg_data[rsb_pkg::STALE_W-1:0];
            end
            if (req_valid && !req_stall)
            begin
                if (req.command == rsb_pkg::CMD_WANT)
                    predict_want(req.key, req.now_ms);
                else if (req.command == rsb_pkg::CMD_TAKE)
                    predict_take(req.now_ms);
                else if (req.command == rsb_pkg::CMD_FINISH)
                    predict_finish(req.key, req.fetch_ok, req.now_ms);
            end
        end
    end

endmodule

// ===== sim/tb_request_scheduler_with_backoff_top.sv =====
`timescale 1ns / 1ps

module tb_request_scheduler_with_backoff_top;

    localparam int TW = rsb_pkg::TIME_W;
    localparam int KW = rsb_pkg::OUT_KEY_W;
    localparam logic [rsb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_stall;
    rsb_pkg::req_t                 req;
    logic                          rsp_valid;
    logic                          rsp_stall;
    rsb_pkg::rsp_t                 rsp;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rsb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rsb_pkg::CFG_DAT_W-1:0] cfg_data;
    int                            errors;
    int                            outstanding;

    logic                 quiet;
    logic                 long_hold;
    logic [TW-1:0]        now;
    logic [KW-1:0]        key_pool [12];
    logic [KW-1:0]        used_keys [$];

    request_scheduler_with_backoff_top uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rsb_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("tb_request_scheduler_with_backoff_top: FAIL");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int left;
        rsp_stall = 1'b0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (quiet)
                rsp_stall <= 1'b0;
            else if (left > 0)
                left--;
            else if ($urandom_range(0, 3) == 0)
            begin
                rsp_stall <= ~rsp_stall;
                left = int'($urandom_range(1, 13)) - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic send(input logic [rsb_pkg::CMD_W-1:0] c, input logic [KW-1:0] k,
                        input logic ok);
        rsb_pkg::req_t r;
        r.command  = c;
        r.key      = k;
        r.fetch_ok = ok;
        r.now_ms   = now;
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [rsb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rsb_pkg::CFG_DAT_W-1:0] d);
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int n);
        int pick;
        logic [KW-1:0] k;
        logic ok;
        for (int i = 0; i < n; i++)
        begin
            now = now + TW'($urandom_range(0, 700));
            k = ($urandom_range(0, 7) == 0) ? $urandom() : key_pool[$urandom_range(0, 11)];
            ok = 1'($urandom_range(0, 1));
            pick = int'($urandom_range(0, 99));
            if (pick < 45)
                send(rsb_pkg::CMD_WANT, k, ok);
            else if (pick < 70)
                send(rsb_pkg::CMD_TAKE, k, ok);
            else if (pick < 96)
                send(rsb_pkg::CMD_FINISH, k, ok);
            else
                send(CMD_UNUSED, k, ok);
        end
    endtask

    task automatic clear_keys();
        foreach (used_keys[i])
            send(rsb_pkg::CMD_FINISH, used_keys[i], 1'b1);
        used_keys.delete();
    endtask

    initial
    begin
        logic [KW-1:0] k;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        long_hold = 1'b0;
        now       = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(rsb_pkg::CMD_TAKE, '0, 1'b0);
        send(rsb_pkg::CMD_WANT, key_pool[0], 1'b0);
        send(rsb_pkg::CMD_WANT, key_pool[1], 1'b1);
        now = now + TW'(10);
        send(rsb_pkg::CMD_WANT, key_pool[0], 1'b0);
        send(rsb_pkg::CMD_TAKE, '1, 1'b1);
        send(rsb_pkg::CMD_WANT, key_pool[1], 1'b0);
        send(rsb_pkg::CMD_FINISH, key_pool[1], 1'b0);
        send(rsb_pkg::CMD_WANT, key_pool[1], 1'b0);
        send(rsb_pkg::CMD_FINISH, key_pool[1], 1'b0);
        send(rsb_pkg::CMD_FINISH, key_pool[0], 1'b1);
        send(CMD_UNUSED, key_pool[2], 1'b1);
        send(rsb_pkg::CMD_WANT, key_pool[2], 1'b0);
        now = now + TW'(2001);
        send(rsb_pkg::CMD_WANT, key_pool[3], 1'b0);
        send(rsb_pkg::CMD_TAKE, '0, 1'b0);
        now = now + TW'(5000);
        send(rsb_pkg::CMD_WANT, key_pool[1], 1'b0);
        send(rsb_pkg::CMD_FINISH, key_pool[1], 1'b1);
        send(rsb_pkg::CMD_WANT, key_pool[4], 1'b0);
        now = now - TW'(100);
        send(rsb_pkg::CMD_TAKE, '0, 1'b0);
        send(rsb_pkg::CMD_FINISH, key_pool[5], 1'b1);
        now = now + TW'(200);
        send(rsb_pkg::CMD_TAKE, '0, 1'b0);

        long_hold = 1'b1;
        random_items(15);

        write_reg(rsb_pkg::REG_MAX_IN_FLIGHT, 32'd1);
        write_reg(rsb_pkg::REG_STALE_AFTER, 32'd0);
        random_items(10);

        write_reg(rsb_pkg::REG_MAX_IN_FLIGHT, 32'd0);
        write_reg(rsb_pkg::REG_STALE_AFTER, 32'hFFFF_FFFF);
        for (int i = 0; i < 34; i++)
        begin
            k = $urandom();
            used_keys = {used_keys, k};
            send(rsb_pkg::CMD_WANT, k, 1'b0);
        end
        send(rsb_pkg::CMD_TAKE, '0, 1'b0);
        write_reg(rsb_pkg::REG_MAX_IN_FLIGHT, 32'd8);
        repeat (5)
            send(rsb_pkg::CMD_TAKE, '0, 1'b0);
        clear_keys();
        random_items(10);

        for (int i = 0; i < 33; i++)
        begin
            k = $urandom();
            used_keys = {used_keys, k};
            send(rsb_pkg::CMD_FINISH, k, 1'b0);
        end
        clear_keys();
        for (int i = 0; i < 65; i++)
        begin
            now = now + TW'($urandom_range(0, 100));
            send(rsb_pkg::CMD_FINISH, key_pool[6], 1'b0);
        end
        send(rsb_pkg::CMD_FINISH, key_pool[6], 1'b1);

        write_reg(rsb_pkg::REG_MAX_IN_FLIGHT, 32'd15);
        write_reg(rsb_pkg::REG_STALE_AFTER, 32'd2000);
        random_items(15);

        write_reg(rsb_pkg::REG_MAX_IN_FLIGHT, 32'd3);
        write_reg(rsb_pkg::REG_STALE_AFTER, 32'd500);
        quiet = 1'b1;
        random_items(5);
        now = 48'hFFFF_FFFF_F000;
        random_items(5);
        now = '1;
        send(rsb_pkg::CMD_FINISH, key_pool[7], 1'b0);
        send(rsb_pkg::CMD_WANT, key_pool[7], 1'b0);
        send(rsb_pkg::CMD_WANT, key_pool[8], 1'b1);
        send(rsb_pkg::CMD_TAKE, '0, 1'b0);

        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_request_scheduler_with_backoff_top: PASS");
        else
            $display("tb_request_scheduler_with_backoff_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rsb_pkg.sv
src/rsb_ram.sv
src/rsb_flight.sv
src/request_scheduler_with_backoff_top.sv
src/rsb_checker.sv
sim/rsb_checker.sv
sim/tb_request_scheduler_with_backoff_top.sv
